>>> rtl/scda_pkg.sv
// shared types, constants and codes of the sector cache directory
package scda_pkg;

   localparam int ENTRY_COUNT_DEF       = 16;
   localparam int SECTORS_PER_ENTRY_DEF = 32;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [63:0] INVALID_TAG  = 64'hffff_ffff_ffff_ffff;
   localparam int          WEIGHT_SHIFT = 8;
   localparam logic [31:0] WEIGHT_MAX   = 32'h7fff_ffff;
   localparam int          AGE_SHIFT    = 5;

   localparam logic CSR_DEVICE_TOTAL = 1'b0;
   localparam logic CSR_SECTOR_512   = 1'b1;

   typedef enum logic [1:0] {
      REQ_READ    = 2'd0,
      REQ_WRITE   = 2'd1,
      REQ_FILL    = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_EMPTY   = 3'd0,
      ST_RANGE   = 3'd1,
      ST_BYPASS  = 3'd2,
      ST_HIT     = 3'd3,
      ST_MISS    = 3'd4,
      ST_WRITE   = 3'd5,
      ST_FILLED  = 3'd6,
      ST_FILLERR = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      OP_DIRECT = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2,
      OP_FILL   = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      status_type  status;
      logic [63:0] start;
      logic [15:0] count;
      logic [63:0] dev_sector;
      logic [15:0] dev_count;
      logic        fill_ok;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  entry_index;
      logic [4:0]  sector_offset;
      logic [63:0] device_sector;
      logic [15:0] device_count;
   } rsp_type;

endpackage

>>> rtl/scda_if.sv
// handshake channels of the sector cache directory

interface scda_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] start_sector;
   logic [15:0] sector_count;
   logic        fill_ok;
   modport source (output valid, req_type, start_sector, sector_count, fill_ok, input ready);
   modport sink (input valid, req_type, start_sector, sector_count, fill_ok, output ready);
endinterface

interface scda_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  entry_index;
   logic [4:0]  sector_offset;
   logic [63:0] device_sector;
   logic [15:0] device_count;
   modport source (output valid, status, entry_index, sector_offset, device_sector,
                   device_count, input ready);
   modport sink (input valid, status, entry_index, sector_offset, device_sector,
                 device_count, output ready);
endinterface

interface scda_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/scda_front.sv
// front end: configuration registers, item acceptance and classification
module scda_front #(
   parameter int SECTORS_PER_ENTRY = scda_pkg::SECTORS_PER_ENTRY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   scda_req_if.sink               req_bus,
   scda_csr_if.sink               csr_bus,
   input  scda_pkg::queue_flags_type q_flags,
   output logic                   push,
   output scda_pkg::op_type       push_op
);

   localparam logic [63:0] SPE_64 = 64'(SECTORS_PER_ENTRY);
   localparam logic [15:0] SPE_16 = 16'(SECTORS_PER_ENTRY);

   logic [63:0] total_ff, total_in;
   logic        is512_ff, is512_in;
   logic [63:0] rem;
   logic        out_range;
   logic [15:0] fill_cnt;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_flags.full;
   assign push          = req_bus.valid && !q_flags.full;

   always_comb begin
      total_in = total_ff;
      is512_in = is512_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            scda_pkg::CSR_DEVICE_TOTAL: total_in = csr_bus.data;
            scda_pkg::CSR_SECTOR_512:   is512_in = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 64'd0;
         is512_ff <= 1'b1;
      end else begin
         total_ff <= total_in;
         is512_ff <= is512_in;
      end
   end

   always_comb begin
      rem       = total_ff - req_bus.start_sector;
      out_range = (req_bus.start_sector >= total_ff) || ({48'd0, req_bus.sector_count} > rem);
      fill_cnt  = (rem < SPE_64) ? rem[15:0] : SPE_16;

      push_op.kind       = scda_pkg::OP_DIRECT;
      push_op.status     = scda_pkg::ST_EMPTY;
      push_op.start      = req_bus.start_sector;
      push_op.count      = req_bus.sector_count;
      push_op.dev_sector = 64'd0;
      push_op.dev_count  = 16'd0;
      push_op.fill_ok    = req_bus.fill_ok;

      case (scda_pkg::req_kind_type'(req_bus.req_type))
         scda_pkg::REQ_READ: begin
            if (req_bus.sector_count == 16'd0) begin
               push_op.status = scda_pkg::ST_EMPTY;
            end else if (out_range) begin
               push_op.status = scda_pkg::ST_RANGE;
            end else if (!is512_ff || req_bus.sector_count >= SPE_16) begin
               push_op.status     = scda_pkg::ST_BYPASS;
               push_op.dev_sector = req_bus.start_sector;
               push_op.dev_count  = req_bus.sector_count;
            end else begin
               push_op.kind       = scda_pkg::OP_READ;
               push_op.dev_sector = req_bus.start_sector;
               push_op.dev_count  = fill_cnt;
            end
         end
         scda_pkg::REQ_WRITE: begin
            push_op.kind       = scda_pkg::OP_WRITE;
            push_op.dev_sector = req_bus.start_sector;
            push_op.dev_count  = req_bus.sector_count;
         end
         scda_pkg::REQ_FILL: push_op.kind = scda_pkg::OP_FILL;
         default: push_op.status = scda_pkg::ST_EMPTY;
      endcase
   end

endmodule

>>> rtl/scda_queue.sv
// short item queue between front and back
module scda_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  scda_pkg::op_type          push_op,
   input  logic                      pop,
   output scda_pkg::op_type          pop_op,
   output scda_pkg::queue_flags_type flags
);

   localparam int PTR_W = (scda_pkg::QUEUE_DEPTH > 1) ? $clog2(scda_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(scda_pkg::QUEUE_DEPTH + 1);

   scda_pkg::op_type slot_ff [scda_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(scda_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign flags.full  = (cnt_ff == CNT_W'(scda_pkg::QUEUE_DEPTH));
   assign flags.empty = (cnt_ff == '0);
   assign pop_op      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> rtl/scda_back.sv
// back end: directory store, entry scans, aging, victim choice and result register
module scda_back #(
   parameter int ENTRY_COUNT       = scda_pkg::ENTRY_COUNT_DEF,
   parameter int SECTORS_PER_ENTRY = scda_pkg::SECTORS_PER_ENTRY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scda_pkg::queue_flags_type q_flags,
   input  scda_pkg::op_type          pop_op,
   output logic                      pop,
   scda_rsp_if.source                rsp_bus
);

   localparam int IDX_W  = $clog2(ENTRY_COUNT);
   localparam int SCAN_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(SECTORS_PER_ENTRY);
   localparam int AGE_STEP = SECTORS_PER_ENTRY * 256 / ENTRY_COUNT;
   localparam logic [63:0] SPE_64 = 64'(SECTORS_PER_ENTRY);
   localparam logic signed [33:0] AGE_HI = 34'sh0_7fff_ffff;
   localparam logic signed [33:0] AGE_LO = 34'sh3_8000_0000;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_HIT   = 4'b0010,
      S_AGE   = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   scda_pkg::op_type     op_ff, op_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [ENTRY_COUNT-1:0] tag_vld_ff, tag_vld_in;
   logic [ENTRY_COUNT-1:0] wt_vld_ff, wt_vld_in;
   logic signed [31:0]   best_w_ff, best_w_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]     pend_entry_ff, pend_entry_in;
   logic [63:0]          pend_sector_ff, pend_sector_in;
   logic [CNT_W-1:0]     pend_count_ff, pend_count_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   scda_pkg::rsp_type    rsp_ff, rsp_in;

   logic [63:0] tag_mem [ENTRY_COUNT];
   logic [31:0] wt_mem [ENTRY_COUNT];
   logic [63:0] tag_rd_ff;
   logic [31:0] wt_rd_ff;

   logic             tag_we, wt_we;
   logic [IDX_W-1:0] tag_wa, wt_wa;
   logic [63:0]      tag_wd;
   logic [31:0]      wt_wd;
   logic [IDX_W-1:0] rd_addr;

   logic               cur_tvld, is_last, hit, ovl, pend_ovl;
   logic signed [31:0] cur_w, base_w, hit_w, aged_w;
   logic [32:0]        hit_sum;
   logic signed [32:0] biased, quot;
   logic signed [33:0] aged34;
   logic [IDX_W-1:0]   best_final;

   function automatic logic contains(input logic [63:0] tag, input logic [63:0] s,
                                     input logic [15:0] n);
      logic [64:0] d;
      d = {1'b0, s} - {1'b0, tag};
      contains = !d[64] && (d[63:0] <= SPE_64)
                 && (({1'b0, d[63:0]} + 65'(n)) <= 65'(SECTORS_PER_ENTRY));
   endfunction

   function automatic logic overlaps(input logic [63:0] tag, input logic [63:0] s,
                                     input logic [15:0] n);
      logic [64:0] d;
      logic [63:0] r;
      d = {1'b0, s} - {1'b0, tag};
      r = tag - s;
      overlaps = !d[64] ? (d[63:0] < SPE_64) : (r < {48'd0, n});
   endfunction

   assign rd_addr = scan_ff[IDX_W-1:0];
   assign pop     = (state_ff == S_IDLE) && !q_flags.empty && !rsp_vld_ff;

   assign rsp_bus.valid         = rsp_vld_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.entry_index   = rsp_ff.entry_index;
   assign rsp_bus.sector_offset = rsp_ff.sector_offset;
   assign rsp_bus.device_sector = rsp_ff.device_sector;
   assign rsp_bus.device_count  = rsp_ff.device_count;

   // entry under check, one read behind the scan address
   always_comb begin
      cur_tvld = tag_vld_ff[chk_idx_ff] && (tag_rd_ff != scda_pkg::INVALID_TAG);
      cur_w    = wt_vld_ff[chk_idx_ff] ? wt_rd_ff : 32'sd0;
      is_last  = (chk_idx_ff == IDX_W'(ENTRY_COUNT - 1));
      hit      = cur_tvld && contains(tag_rd_ff, op_ff.start, op_ff.count);
      ovl      = cur_tvld && overlaps(tag_rd_ff, op_ff.start, op_ff.count);
      pend_ovl = overlaps(pend_sector_ff, op_ff.start, op_ff.count);

      base_w  = cur_w[31] ? 32'sd0 : cur_w;
      hit_sum = {1'b0, base_w} + 33'({op_ff.count, 8'd0});
      hit_w   = (hit_sum > 33'(scda_pkg::WEIGHT_MAX)) ? scda_pkg::WEIGHT_MAX : hit_sum[31:0];

      biased = {cur_w[31], cur_w} + (cur_w[31] ? 33'sd31 : 33'sd0);
      quot   = biased >>> scda_pkg::AGE_SHIFT;
      aged34 = {{2{cur_w[31]}}, cur_w} - 34'(AGE_STEP) - {quot[32], quot};
      if (aged34 > AGE_HI) begin
         aged_w = AGE_HI[31:0];
      end else if (aged34 < AGE_LO) begin
         aged_w = AGE_LO[31:0];
      end else begin
         aged_w = aged34[31:0];
      end
      best_final = (aged_w < best_w_ff) ? chk_idx_ff : best_idx_ff;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      scan_in        = scan_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      tag_vld_in     = tag_vld_ff;
      wt_vld_in      = wt_vld_ff;
      best_w_in      = best_w_ff;
      best_idx_in    = best_idx_ff;
      pend_vld_in    = pend_vld_ff;
      pend_entry_in  = pend_entry_ff;
      pend_sector_in = pend_sector_ff;
      pend_count_in  = pend_count_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_bus.ready;
      rsp_in         = rsp_ff;
      tag_we = 1'b0;
      tag_wa = pend_entry_ff;
      tag_wd = pend_sector_ff;
      wt_we  = 1'b0;
      wt_wa  = chk_idx_ff;
      wt_wd  = aged_w;

      if (state_ff != S_IDLE && scan_ff < SCAN_W'(ENTRY_COUNT)) begin
         scan_in    = scan_ff + 1'b1;
         chk_vld_in = 1'b1;
         chk_idx_in = rd_addr;
      end

      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               op_in   = pop_op;
               scan_in = '0;
               rsp_in.status        = pop_op.status;
               rsp_in.entry_index   = 4'd0;
               rsp_in.sector_offset = 5'd0;
               rsp_in.device_sector = pop_op.dev_sector;
               rsp_in.device_count  = pop_op.dev_count;
               case (pop_op.kind)
                  scda_pkg::OP_DIRECT: rsp_vld_in = 1'b1;
                  scda_pkg::OP_READ:   state_in = S_HIT;
                  scda_pkg::OP_WRITE:  state_in = S_WRITE;
                  scda_pkg::OP_FILL: begin
                     rsp_vld_in    = 1'b1;
                     rsp_in.status = scda_pkg::ST_FILLERR;
                     if (pend_vld_ff) begin
                        rsp_in.entry_index   = 4'(pend_entry_ff);
                        rsp_in.device_sector = pend_sector_ff;
                        if (pop_op.fill_ok) begin
                           rsp_in.status = scda_pkg::ST_FILLED;
                           tag_we = 1'b1;
                           tag_vld_in[pend_entry_ff] = 1'b1;
                           wt_we = 1'b1;
                           wt_wa = pend_entry_ff;
                           wt_wd = 32'(pend_count_ff) << scda_pkg::WEIGHT_SHIFT;
                           wt_vld_in[pend_entry_ff] = 1'b1;
                        end
                     end
                     pend_vld_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_HIT: begin
            if (chk_vld_ff) begin
               if (hit) begin
                  wt_we = 1'b1;
                  wt_wd = hit_w;
                  wt_vld_in[chk_idx_ff] = 1'b1;
                  rsp_in.status        = scda_pkg::ST_HIT;
                  rsp_in.entry_index   = 4'(chk_idx_ff);
                  rsp_in.sector_offset = 5'(op_ff.start - tag_rd_ff);
                  rsp_in.device_sector = 64'd0;
                  rsp_in.device_count  = 16'd0;
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end else if (is_last) begin
                  scan_in     = '0;
                  chk_vld_in  = 1'b0;
                  best_w_in   = scda_pkg::WEIGHT_MAX;
                  best_idx_in = '0;
                  state_in    = S_AGE;
               end
            end
         end
         S_AGE: begin
            if (chk_vld_ff) begin
               wt_we = 1'b1;
               wt_vld_in[chk_idx_ff] = 1'b1;
               if (aged_w < best_w_ff) begin
                  best_w_in   = aged_w;
                  best_idx_in = chk_idx_ff;
               end
               if (is_last) begin
                  tag_vld_in[best_final] = 1'b0;
                  pend_vld_in    = 1'b1;
                  pend_entry_in  = best_final;
                  pend_sector_in = op_ff.start;
                  pend_count_in  = CNT_W'(op_ff.count);
                  rsp_in.status      = scda_pkg::ST_MISS;
                  rsp_in.entry_index = 4'(best_final);
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_WRITE: begin
            if (chk_vld_ff) begin
               if (ovl) begin
                  tag_vld_in[chk_idx_ff] = 1'b0;
               end
               if (is_last) begin
                  if (pend_vld_ff && pend_ovl) begin
                     pend_vld_in = 1'b0;
                  end
                  rsp_in.status = scda_pkg::ST_WRITE;
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         scan_ff        <= '0;
         chk_vld_ff     <= 1'b0;
         tag_vld_ff     <= '0;
         wt_vld_ff      <= '0;
         pend_vld_ff    <= 1'b0;
         pend_entry_ff  <= '0;
         pend_sector_ff <= 64'd0;
         pend_count_ff  <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_ff        <= scan_in;
         chk_vld_ff     <= chk_vld_in;
         tag_vld_ff     <= tag_vld_in;
         wt_vld_ff      <= wt_vld_in;
         pend_vld_ff    <= pend_vld_in;
         pend_entry_ff  <= pend_entry_in;
         pend_sector_ff <= pend_sector_in;
         pend_count_ff  <= pend_count_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      chk_idx_ff  <= chk_idx_in;
      best_w_ff   <= best_w_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_wa] <= wt_wd;
      end
      wt_rd_ff <= wt_mem[rd_addr];
   end

endmodule

>>> rtl/sector_cache_directory_aging_core.sv
// empty, range, bypass and fill items are answered without an entry scan; a hit or a write
// ends within one scan, a miss after a lookup scan and an aging scan
// throughput: one item at a time in the back end; the entry scan over the directory store
// reads one entry per cycle, once for lookup and, on a miss, once for aging
// reset: synchronous, clears entry and weight valid bits, pending fill and queue at once
module sector_cache_directory_aging_core #(
   parameter int ENTRY_COUNT       = scda_pkg::ENTRY_COUNT_DEF,
   parameter int SECTORS_PER_ENTRY = scda_pkg::SECTORS_PER_ENTRY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   scda_req_if.sink    req_bus,
   scda_rsp_if.source  rsp_bus,
   scda_csr_if.sink    csr_bus
);

   scda_pkg::queue_flags_type q_flags;
   scda_pkg::op_type          push_op, pop_op;
   logic                      push, pop;

   scda_front #(
      .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_flags (q_flags),
      .push    (push),
      .push_op (push_op)
   );

   scda_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .flags   (q_flags)
   );

   scda_back #(
      .ENTRY_COUNT       (ENTRY_COUNT),
      .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_flags (q_flags),
      .pop_op  (pop_op),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
